// ===== rtl/core/werm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// werm_pkg
// types and constants shared by the event rate meter modules
// ----------------------------------------------------------------------------
package werm_pkg;

  localparam int unsigned ChanW = 3;
  localparam logic [31:0] WindowReset = 32'd5000;
  localparam logic [7:0]  ActiveReset = 8'hFF;
  localparam logic [19:0] MhzScale = 20'd1000000;

  typedef enum logic {
    FUNC_ARRIVAL = 1'b0,
    FUNC_TICK    = 1'b1
  } func_e;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_ACTIVE = 1'b1
  } reg_e;

  typedef struct packed {
    logic        func;
    logic [2:0]  channel;
    logic [31:0] time_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [31:0] rate_mhz;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEXT,
    ST_APPEND,
    ST_RDFRONT,
    ST_WAITRD,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } back_state_e;

endpackage

// ===== rtl/core/werm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// werm_front
// accepts input words, counts arrivals, queues ticks with a count snapshot
// ----------------------------------------------------------------------------
module werm_front import werm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        tick_valid_o,
  input  logic        tick_pop_i,
  output logic [31:0] tick_time_o,
  output logic [NUM_CHANNELS*32-1:0] tick_counts_o
);

  localparam int unsigned QD = 2;

  logic [31:0] counts_q [NUM_CHANNELS];
  logic [31:0] qtime_q [QD];
  logic [NUM_CHANNELS*32-1:0] qcnt_q [QD];
  logic [1:0] fill_q;
  logic       wr_q, rd_q;
  logic       acc, is_tick;
  logic [NUM_CHANNELS*32-1:0] snap;

  assign in_stall_o = (fill_q == 2'd2);
  assign acc = in_valid_i && !in_stall_o;
  assign is_tick = (in_word_i.func == FUNC_TICK);

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) snap[c*32 +: 32] = counts_q[c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) counts_q[c] <= '0;
    end else if (acc && !is_tick && ({29'd0, in_word_i.channel} < NUM_CHANNELS)) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (in_word_i.channel == ChanW'(c)) counts_q[c] <= counts_q[c] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_tick) begin
      qtime_q[wr_q] <= in_word_i.time_ms;
      qcnt_q[wr_q]  <= snap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      if (acc && is_tick) wr_q <= ~wr_q;
      if (tick_pop_i) rd_q <= ~rd_q;
      fill_q <= fill_q + {1'b0, acc && is_tick} - {1'b0, tick_pop_i};
    end
  end

  assign tick_valid_o  = (fill_q != 2'd0);
  assign tick_time_o   = qtime_q[rd_q];
  assign tick_counts_o = qcnt_q[rd_q];

endmodule

// ===== rtl/core/werm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// werm_back
// per-channel sample rings, window trim and rate division for each tick
// ----------------------------------------------------------------------------
module werm_back import werm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned MAX_SAMPLES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] window_i,
  input  logic [7:0]  active_i,
  input  logic        tick_valid_i,
  output logic        tick_pop_o,
  input  logic [31:0] tick_time_i,
  input  logic [NUM_CHANNELS*32-1:0] tick_counts_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o
);

  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SW = $clog2(MAX_SAMPLES);
  localparam int unsigned FW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = CW + SW;
  localparam int unsigned NL = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
  localparam int unsigned LW = $clog2(NL + 1);

  logic [63:0] mem [NUM_CHANNELS * (1 << SW)];
  logic [63:0] rdata_q;
  logic [SW-1:0] head_q [NUM_CHANNELS];
  logic [FW-1:0] fill_q [NUM_CHANNELS];

  back_state_e state_q, state_d;
  logic [LW-1:0] ch_q;
  logic [CW-1:0] chi;
  logic [31:0]  cnt, span, delta;
  logic [63:0]  num_q, rem_q, quo_q;
  logic [6:0]   bit_q;
  logic [31:0]  span_q;
  logic         zero_q;
  logic [SW-1:0] h;
  logic [SW-1:0] hn;
  logic [FW-1:0] f;
  logic [SW:0]   pos;
  logic [SW-1:0] slot;
  logic [AW-1:0] waddr, raddr;
  logic         more;
  logic [LW-1:0] nxt;
  logic [LW-1:0] first;
  logic [64:0]  trial;

  assign chi = CW'(ch_q);
  assign cnt = tick_counts_i[chi*32 +: 32];
  assign h = head_q[chi];
  assign f = fill_q[chi];
  assign hn = (h == SW'(MAX_SAMPLES - 1)) ? '0 : h + SW'(1);
  assign pos = {1'b0, h} + (SW+1)'(f);
  assign slot = (pos >= (SW+1)'(MAX_SAMPLES)) ? SW'(pos - (SW+1)'(MAX_SAMPLES)) :
                                                pos[SW-1:0];
  assign waddr = {chi, slot};
  assign raddr = {chi, h};
  assign span = tick_time_i - rdata_q[63:32];
  assign delta = cnt - rdata_q[31:0];

  always_comb begin
    nxt = LW'(NL);
    for (int c = NL - 1; c >= 0; c--) begin
      if (active_i[c] && (LW'(c) > ch_q)) nxt = LW'(c);
    end
  end
  always_comb begin
    first = LW'(NL);
    for (int c = NL - 1; c >= 0; c--) begin
      if (active_i[c]) first = LW'(c);
    end
  end
  always_comb begin
    more = 1'b0;
    for (int c = 0; c < NL; c++) if (active_i[c] && (LW'(c) > ch_q)) more = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (tick_valid_i) state_d = ST_NEXT;
      ST_NEXT:    state_d = (ch_q == LW'(NL)) ? ST_IDLE : ST_APPEND;
      ST_APPEND:  state_d = ST_RDFRONT;
      ST_RDFRONT: state_d = ST_WAITRD;
      ST_WAITRD:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (f > FW'(2) && (span > window_i)) state_d = ST_RDFRONT;
        else state_d = ST_MUL;
      end
      ST_MUL:     state_d = ST_DIV;
      ST_DIV:     if (bit_q == 7'd0 || zero_q) state_d = ST_EMIT;
      ST_EMIT:    if (!out_stall_i) state_d = ST_NEXT;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    trial = {rem_q, num_q[63]} - {33'd0, span_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        head_q[c] <= '0;
        fill_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (tick_valid_i) ch_q <= first;
        end
        ST_APPEND: begin
          if (f >= FW'(MAX_SAMPLES)) begin
            head_q[chi] <= hn;
            fill_q[chi] <= FW'(MAX_SAMPLES);
          end else begin
            fill_q[chi] <= f + FW'(1);
          end
        end
        ST_CHECK: begin
          if (f > FW'(2) && (span > window_i)) begin
            head_q[chi] <= hn;
            fill_q[chi] <= f - FW'(1);
          end
        end
        ST_EMIT: if (!out_stall_i) ch_q <= nxt;
        default: ;
      endcase
    end
  end

  // sample memory, multiply and divide
  always_ff @(posedge clk_i) begin
    if (state_q == ST_APPEND) begin
      mem[(f >= FW'(MAX_SAMPLES)) ? {chi, h} : waddr] <= {tick_time_i, cnt};
    end
    rdata_q <= mem[raddr];
    if (state_q == ST_MUL) begin
      span_q <= span;
      zero_q <= (f < FW'(2)) || (span == 32'd0);
      num_q  <= {32'd0, delta} * {44'd0, MhzScale};
      rem_q  <= '0;
      quo_q  <= '0;
      bit_q  <= 7'd64;
    end else if (state_q == ST_DIV && bit_q != 7'd0 && !zero_q) begin
      num_q <= {num_q[62:0], 1'b0};
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], num_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
      bit_q <= bit_q - 7'd1;
    end
  end

  logic [31:0] rate;
  assign rate = zero_q ? 32'd0 : ((quo_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_q[31:0]);

  assign out_valid_o = (state_q == ST_EMIT);
  assign out_word_o  = '{out_channel: 3'(ch_q), rate_mhz: rate, last: !more};
  assign tick_pop_o  = (state_q == ST_NEXT) && (ch_q == LW'(NL));

endmodule

// ===== rtl/core/windowed_event_rate_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_event_rate_meter
// per-channel windowed event rate meter with apb configuration
// ----------------------------------------------------------------------------
// An arrival word only bumps its channel counter. A tick is queued (two deep)
// with a snapshot of all counts, and the input stalls while two ticks wait.
// The back end walks the active channels in order: it selects the channel,
// appends the sample, reads the oldest sample (registered memory read) and
// checks it, trimming it and reading the next while more than two samples
// are held and the span exceeds the window, multiplies delta by 10^6,
// divides by the span one quotient bit a cycle (skipped when the span is zero
// or fewer than two samples are held), and hands out the result word, holding
// it while the output stalls.
module windowed_event_rate_meter import werm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned MAX_SAMPLES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] window_q;
  logic [7:0]  active_q;
  logic        tv, pop;
  logic [31:0] tt;
  logic [NUM_CHANNELS*32-1:0] tc;
  reg_e        ridx;

  assign pready = 1'b1;
  assign ridx = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
      active_q <= ActiveReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (ridx)
        REG_WINDOW: window_q <= pwdata;
        REG_ACTIVE: active_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_WINDOW: prdata = window_q;
      REG_ACTIVE: prdata = {24'd0, active_q};
      default:    prdata = '0;
    endcase
  end

  werm_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .tick_valid_o(tv), .tick_pop_i(pop), .tick_time_o(tt), .tick_counts_o(tc)
  );

  werm_back #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk_i, .rst_ni, .window_i(window_q), .active_i(active_q),
    .tick_valid_i(tv), .tick_pop_o(pop), .tick_time_i(tt), .tick_counts_i(tc),
    .out_valid_o, .out_stall_i, .out_word_o
  );

endmodule
